@@ sv/amqpdf_pkg.sv @@
// ----------------------------------------------------------------------------
// amqpdf_pkg
// Shared codes, constants and the result record of the frame deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package amqpdf_pkg;

  // Frame end marker and size limits
  localparam logic [7:0]  FRAME_END_MARK  = 8'hCE;
  localparam logic [31:0] MAX_FRAME_RESET = 32'd150000;
  localparam logic [32:0] FRAME_OVERHEAD  = 33'd8;

  // Deframer phase codes (code 3 is unused and behaves as header)
  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_END     = 2'd2;

  // Last header byte position
  localparam logic [2:0] HDR_LAST_IDX = 3'd6;

  // Result status codes
  localparam logic [2:0] ST_HEADER   = 3'd0;
  localparam logic [2:0] ST_PAYLOAD  = 3'd1;
  localparam logic [2:0] ST_DONE     = 3'd2;
  localparam logic [2:0] ST_BADEND   = 3'd3;
  localparam logic [2:0] ST_OVERSIZE = 3'd4;

  // Register addresses (word index taken from paddr)
  localparam logic REG_MAX_FRAME = 1'b0;

  // One result beat
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  payload_byte;
    logic [7:0]  frame_type;
    logic [15:0] channel_number;
    logic [31:0] payload_length;
  } res_t;

endpackage

@@ sv/amqpdf_regs.sv @@
// ----------------------------------------------------------------------------
// amqpdf_regs
// APB register file holding the maximum frame size.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module amqpdf_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] max_frame_bytes_o
);

  logic [31:0] max_frame_q;
  logic        wr_en;

  // Write on the access phase of a write transfer
  assign wr_en  = psel && penable && pwrite && (paddr[2] == amqpdf_pkg::REG_MAX_FRAME);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frame_q <= amqpdf_pkg::MAX_FRAME_RESET;
    end else if (wr_en) begin
      max_frame_q <= pwdata;
    end
  end

  // Read back the register, zero elsewhere
  always_comb begin
    case (paddr[2])
      amqpdf_pkg::REG_MAX_FRAME: prdata = max_frame_q;
      default:                   prdata = 32'd0;
    endcase
  end

  assign max_frame_bytes_o = max_frame_q;

endmodule

@@ sv/amqp_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// amqp_frame_deframer
// Byte-serial AMQP 0-9-1 frame deframer with header, payload and end checks.
// ----------------------------------------------------------------------------
// Takes one stream byte per clock while in_stall_o is low and gives exactly
// one result beat per byte, registered in the output register or, while the
// output stalls, in the skid register. The header, payload and end-marker
// state is updated directly from each accepted byte, so a byte can enter
// every cycle. Results sit in an output register backed by a one-entry skid
// register: input stall rises only when both are full, so a stalled output
// costs no input cycle until the second result is waiting. Frames whose
// length plus 8 exceeds max_frame_bytes are flagged as oversize on the last
// header byte and the block resumes hunting for a header; a wrong end marker
// is reported as a bad end and hunting resumes likewise. Write the size
// register only while no beat is in flight.
`timescale 1ns / 1ps

module amqp_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic [7:0]  data_byte_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  // result output
  output logic [2:0]  status_o,
  output logic [7:0]  payload_byte_o,
  output logic [7:0]  frame_type_o,
  output logic [15:0] channel_number_o,
  output logic [31:0] payload_length_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] max_frame_bytes;

  amqpdf_regs u_regs (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .max_frame_bytes_o (max_frame_bytes)
  );

  // Deframer state
  logic [1:0]  phase_q, phase_d;
  logic [2:0]  hdr_idx_q, hdr_idx_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] len_q, len_d;
  logic [31:0] left_q, left_d;

  // Output buffer
  amqpdf_pkg::res_t out_q, skid_q, res_d;
  logic             out_vld_q, skid_vld_q;
  logic             in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_vld_q && !out_stall_i;

  // Next state and result for the current beat
  always_comb begin
    phase_d   = phase_q;
    hdr_idx_d = hdr_idx_q;
    type_d    = type_q;
    chan_d    = chan_q;
    len_d     = len_q;
    left_d    = left_q;
    res_d.status       = amqpdf_pkg::ST_HEADER;
    res_d.payload_byte = 8'd0;

    case (phase_q)
      amqpdf_pkg::PH_PAYLOAD: begin
        res_d.status       = amqpdf_pkg::ST_PAYLOAD;
        res_d.payload_byte = data_byte_i;
        left_d             = left_q - 32'd1;
        if (left_q == 32'd1) begin
          phase_d = amqpdf_pkg::PH_END;
        end
      end
      amqpdf_pkg::PH_END: begin
        res_d.status = (data_byte_i == amqpdf_pkg::FRAME_END_MARK) ?
                       amqpdf_pkg::ST_DONE : amqpdf_pkg::ST_BADEND;
        phase_d   = amqpdf_pkg::PH_HEADER;
        hdr_idx_d = 3'd0;
      end
      default: begin
        phase_d = amqpdf_pkg::PH_HEADER;
        // Assemble the big-endian header fields
        if (hdr_idx_q == 3'd0) begin
          type_d = data_byte_i;
          chan_d = 16'd0;
          len_d  = 32'd0;
        end else if (hdr_idx_q <= 3'd2) begin
          chan_d = {chan_q[7:0], data_byte_i};
        end else begin
          len_d = {len_q[23:0], data_byte_i};
        end
        if (hdr_idx_q < amqpdf_pkg::HDR_LAST_IDX) begin
          hdr_idx_d = hdr_idx_q + 3'd1;
        end else begin
          // Header complete: size check, then payload, end marker or back to header hunting
          hdr_idx_d = 3'd0;
          if (({1'b0, len_d} + amqpdf_pkg::FRAME_OVERHEAD) > {1'b0, max_frame_bytes}) begin
            res_d.status = amqpdf_pkg::ST_OVERSIZE;
          end else if (len_d == 32'd0) begin
            phase_d = amqpdf_pkg::PH_END;
          end else begin
            left_d  = len_d;
            phase_d = amqpdf_pkg::PH_PAYLOAD;
          end
        end
      end
    endcase

    res_d.frame_type     = type_d;
    res_d.channel_number = chan_d;
    res_d.payload_length = len_d;
  end

  // Advance state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= amqpdf_pkg::PH_HEADER;
      hdr_idx_q <= 3'd0;
      type_q    <= 8'd0;
      chan_q    <= 16'd0;
      len_q     <= 32'd0;
      left_q    <= 32'd0;
    end else if (in_acc) begin
      phase_q   <= phase_d;
      hdr_idx_q <= hdr_idx_d;
      type_q    <= type_d;
      chan_q    <= chan_d;
      len_q     <= len_d;
      left_q    <= left_d;
    end
  end

  // Output register with skid: hold a second result while the output stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (skid_vld_q) begin
        if (out_acc) begin
          out_vld_q  <= 1'b1;
          skid_vld_q <= 1'b0;
        end
      end else if (in_acc) begin
        if (out_vld_q && out_stall_i) begin
          skid_vld_q <= 1'b1;
        end else begin
          out_vld_q <= 1'b1;
        end
      end else if (out_acc) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_acc) begin
        out_q <= skid_q;
      end
    end else if (in_acc) begin
      if (out_vld_q && out_stall_i) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign in_stall_o       = skid_vld_q;
  assign out_valid_o      = out_vld_q;
  assign status_o         = out_q.status;
  assign payload_byte_o   = out_q.payload_byte;
  assign frame_type_o     = out_q.frame_type;
  assign channel_number_o = out_q.channel_number;
  assign payload_length_o = out_q.payload_length;

  // Skid entry only fills behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register valid while output register empty");

  // Payload phase always has bytes left to pass
  a_payload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == amqpdf_pkg::PH_PAYLOAD) |-> (left_q != 32'd0))
    else $error("payload phase with no bytes left");

  // Header position stays within the seven header bytes
  a_hdr_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_idx_q <= amqpdf_pkg::HDR_LAST_IDX)
    else $error("header index out of range");

  // Oversize reported only when the frame really exceeds the limit
  a_oversize: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_q.status == amqpdf_pkg::ST_OVERSIZE)) |->
      (({1'b0, out_q.payload_length} + amqpdf_pkg::FRAME_OVERHEAD) >
       {1'b0, max_frame_bytes}))
    else $error("oversize reported for a frame within the limit");

endmodule

@@ test/amqp_frame_deframer_check.sv @@
// ----------------------------------------------------------------------------
// amqp_frame_deframer_check
// Watches the deframer's byte and result channels and checks every result.
// ----------------------------------------------------------------------------
// Each byte accepted on the input channel is run through a cycle-free model of
// the header, payload and end-marker tracking. The result that byte should give
// is queued. Each result beat taken from the output channel is compared with
// the oldest queued result. Writes on the register port update the model's
// size limit. The count of failures and of results still owed is handed to
// the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module amqp_frame_deframer_check
  import amqpdf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte channel as seen on the block's pins
  input  logic [7:0]  data_byte_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  // result channel as seen on the block's pins
  input  logic [2:0]  status_i,
  input  logic [7:0]  payload_byte_i,
  input  logic [7:0]  frame_type_i,
  input  logic [15:0] channel_number_i,
  input  logic [31:0] payload_length_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  // totals for the verdict
  output int unsigned mismatch_count_o,
  output int unsigned owed_count_o
);

  // Model state of the deframer
  logic [31:0] max_frame;
  logic [1:0]  phase;
  logic [2:0]  hdr_idx;
  logic [7:0]  held_type;
  logic [15:0] held_chan;
  logic [31:0] held_len;
  logic [31:0] bytes_left;

  res_t        owed_results[$];
  int unsigned mismatches;

  // Advance the frame tracking by one byte and give the result it causes
  function automatic res_t deframe_byte(input logic [7:0] b);
    res_t r;
    r = '0;
    r.status = ST_HEADER;
    if (phase == PH_PAYLOAD) begin
      r.status       = ST_PAYLOAD;
      r.payload_byte = b;
      bytes_left     = bytes_left - 32'd1;
      if (bytes_left == 32'd0) begin
        phase = PH_END;
      end
    end else if (phase == PH_END) begin
      r.status = (b == FRAME_END_MARK) ? ST_DONE : ST_BADEND;
      phase    = PH_HEADER;
      hdr_idx  = 3'd0;
    end else begin
      // header hunting, the unused phase code included
      phase = PH_HEADER;
      if (hdr_idx == 3'd0) begin
        held_type = b;
        held_chan = '0;
        held_len  = '0;
      end else if (hdr_idx <= 3'd2) begin
        held_chan = {held_chan[7:0], b};
      end else begin
        held_len = {held_len[23:0], b};
      end
      if (hdr_idx < HDR_LAST_IDX) begin
        hdr_idx = hdr_idx + 3'd1;
      end else begin
        hdr_idx = 3'd0;
        // 33-bit sum so that lengths near the top cannot wrap
        if ({1'b0, held_len} + FRAME_OVERHEAD > {1'b0, max_frame}) begin
          r.status = ST_OVERSIZE;
        end else if (held_len == 32'd0) begin
          phase = PH_END;
        end else begin
          bytes_left = held_len;
          phase      = PH_PAYLOAD;
        end
      end
    end
    r.frame_type     = held_type;
    r.channel_number = held_chan;
    r.payload_length = held_len;
    return r;
  endfunction

  // Predict on each accepted byte, compare on each accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    res_t got;
    res_t want;
    if (!rst_ni) begin
      max_frame  = MAX_FRAME_RESET;
      phase      = PH_HEADER;
      hdr_idx    = 3'd0;
      held_type  = '0;
      held_chan  = '0;
      held_len   = '0;
      bytes_left = '0;
      mismatches = 0;
      owed_results.delete();
      mismatch_count_o <= 0;
      owed_count_o     <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        owed_results.push_back(deframe_byte(data_byte_i));
      end
      if (out_valid_i && !out_stall_i) begin
        got = {status_i, payload_byte_i, frame_type_i, channel_number_i, payload_length_i};
        if (owed_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result beat with none owed: status %0d byte %h type %h chan %h len %h",
                     $realtime, got.status, got.payload_byte, got.frame_type,
                     got.channel_number, got.payload_length);
          end
        end else begin
          want = owed_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch (exp / got): status %0d / %0d, byte %h / %h",
                       $realtime, want.status, got.status, want.payload_byte,
                       got.payload_byte);
              $display("    type %h / %h, chan %h / %h, len %h / %h",
                       want.frame_type, got.frame_type, want.channel_number,
                       got.channel_number, want.payload_length, got.payload_length);
            end
          end
        end
      end
      // the register changes at this edge, after the byte above has used it
      if (psel && penable && pwrite && pready && paddr[2:2] == REG_MAX_FRAME) begin
        max_frame = pwdata;
      end
      mismatch_count_o <= mismatches;
      owed_count_o     <= owed_results.size();
    end
  end

endmodule

@@ test/amqp_frame_deframer_test.sv @@
// ----------------------------------------------------------------------------
// amqp_frame_deframer_test
// Stimulus and verdict for the byte-serial AMQP frame deframer.
// ----------------------------------------------------------------------------
// A few directed frames cover the field extremes, an empty payload, a bad end
// marker and an oversize length at the top of the range. The random part then
// runs through several size limits (smallest legal, below legal, the reset
// value, the largest and small random ones), mostly as well-formed frames with
// random content, with bad end markers, sizes at the limit and garbled headers
// mixed in. Sender gaps and receiver stalls vary over three idling modes.
// Results are checked by the checker instance beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module amqp_frame_deframer_test;
  import amqpdf_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_BYTES = 1300;
  localparam int unsigned SEGMENTS     = 12;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic [7:0]  data_byte_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        out_stall_i = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;

  logic        in_stall_o;
  logic [2:0]  status_o;
  logic [7:0]  payload_byte_o;
  logic [7:0]  frame_type_o;
  logic [15:0] channel_number_o;
  logic [31:0] payload_length_o;
  logic        out_valid_o;
  logic [31:0] prdata;
  logic        pready;

  int unsigned mismatch_count;
  int unsigned owed_count;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned bytes_sent     = 0;
  int unsigned cycles         = 0;
  logic [31:0] max_setting    = MAX_FRAME_RESET;

  always #5 clk_i = ~clk_i;

  amqp_frame_deframer u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .data_byte_i      (data_byte_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .status_o         (status_o),
    .payload_byte_o   (payload_byte_o),
    .frame_type_o     (frame_type_o),
    .channel_number_o (channel_number_o),
    .payload_length_o (payload_length_o),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  amqp_frame_deframer_check u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .data_byte_i      (data_byte_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .status_i         (status_o),
    .payload_byte_i   (payload_byte_o),
    .frame_type_i     (frame_type_o),
    .channel_number_i (channel_number_o),
    .payload_length_i (payload_length_o),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .mismatch_count_o (mismatch_count),
    .owed_count_o     (owed_count)
  );

  // Stall the result channel at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offer one byte, with random gaps ahead of it, and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Seven header bytes, multi-byte fields big-endian
  task automatic send_header(input logic [7:0] ftype, input logic [15:0] chan,
                             input logic [31:0] len);
    send_byte(ftype);
    send_byte(chan[15:8]);
    send_byte(chan[7:0]);
    send_byte(len[31:24]);
    send_byte(len[23:16]);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
  endtask

  // Header with random content; payload and end marker only if the size fits
  task automatic send_frame();
    logic [31:0] len;
    logic [32:0] lo;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    lo   = (max_setting < 32'd8) ? 33'd0 : {1'b0, max_setting} - 33'd7;
    if (pick < 20) begin
      len = $urandom_range(32'hFFFF_FFFF, lo[31:0]);
    end else if (pick < 35 && max_setting >= 32'd8 && max_setting <= 32'd28) begin
      // right at the limit or one over it
      len = max_setting - 32'd8 + $urandom_range(0, 1);
    end else begin
      len = $urandom_range(0, 12);
    end
    send_header(8'($urandom), 16'($urandom), len);
    if ({1'b0, len} + FRAME_OVERHEAD <= {1'b0, max_setting}) begin
      repeat (len) send_byte(8'($urandom));
      send_byte(($urandom_range(0, 99) < 85) ? FRAME_END_MARK : 8'($urandom));
    end
  endtask

  // Random bytes padded to a header whose length is far too large, so the
  // block drops it as oversize and stays aligned to the next frame
  task automatic send_garbled_header();
    int unsigned n;
    logic [7:0]  b;
    n = $urandom_range(1, 6);
    for (int i = 0; i < 7; i++) begin
      b = (i < n) ? 8'($urandom) : 8'hFF;
      if (i == 3 && b == 8'h00) begin
        b = 8'h01;
      end
      send_byte(b);
    end
  endtask

  // Stop offering and wait until every owed result has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (owed_count != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the size limit over the register port while the block is idle
  task automatic write_max_frame(input logic [31:0] value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_MAX_FRAME, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    max_setting = value;
  endtask

  initial begin
    logic [31:0] limit;
    int unsigned target;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames at the reset size limit
    send_idle_pct  = 36;
    recv_stall_pct = 77;
    send_header(8'h01, 16'h0000, 32'd1);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_header(8'hFF, 16'hFFFF, 32'd0);
    send_byte(FRAME_END_MARK);
    send_header(8'h00, 16'h0000, 32'hFFFF_FFFF);

    // Random frames over several size limits and idling modes
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 4)
        0: begin
          send_idle_pct  = 36;
          recv_stall_pct = 77;
        end
        1: begin
          send_idle_pct  = 77;
          recv_stall_pct = 36;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      case (seg % 6)
        0:       limit = 32'd8;
        1:       limit = 32'd20;
        2:       limit = 32'hFFFF_FFFF;
        3:       limit = 32'd5;
        4:       limit = MAX_FRAME_RESET;
        default: limit = $urandom_range(8, 64);
      endcase
      write_max_frame(limit);
      target = bytes_sent + RANDOM_BYTES / SEGMENTS;
      while (bytes_sent < target) begin
        if (max_setting <= MAX_FRAME_RESET && $urandom_range(0, 99) < 10) begin
          send_garbled_header();
        end else begin
          send_frame();
        end
      end
    end

    drain();
    if (mismatch_count == 0 && owed_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ amqp_frame_deframer.f @@
sv/amqpdf_pkg.sv
sv/amqpdf_regs.sv
sv/amqp_frame_deframer.sv
test/amqp_frame_deframer_check.sv
test/amqp_frame_deframer_test.sv
